// ===== rtl/core/etfb_pkg.sv =====
`default_nettype none
package etfb_pkg;

  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] XON_BYTE    = 8'h11;
  localparam logic [7:0] XOFF_BYTE   = 8'h13;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] TYPE_TX     = 8'h10;
  localparam logic [7:0] FRAME_ID    = 8'h01;
  localparam logic [7:0] RSV_HI      = 8'hFF;
  localparam logic [7:0] RSV_LO      = 8'hFE;
  localparam logic [7:0] RADIUS      = 8'h00;
  localparam logic [15:0] HDR_EXTRA  = 16'd14;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [4:0] POS_HDR_LAST = 5'd16;
  localparam logic [4:0] POS_CS_START = 5'd17;
  localparam logic [4:0] POS_CS_DATA  = 5'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic        err;
    logic        close;
    logic [63:0] dest;
    logic [7:0]  opts;
    logic [15:0] lenf;
    logic [7:0]  data;
    logic [7:0]  csum;
  } entry_t;

  function automatic logic needs_esc(input logic [7:0] b);
    needs_esc = (b == START_DELIM) || (b == ESC_BYTE) || (b == XON_BYTE) ||
                (b == XOFF_BYTE);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/etfb_front.sv =====
`default_nettype none
module etfb_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            command,
  input  wire logic [63:0]     dest_address,
  input  wire logic [7:0]      tx_options,
  input  wire logic [15:0]     payload_length,
  input  wire logic [7:0]      data_byte,
  output logic                 push,
  output etfb_pkg::entry_t     push_entry,
  input  wire logic            q_full
);
  import etfb_pkg::*;

  logic        frame_open, frame_open_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  hdr_sum;
  logic [7:0]  data_sum;
  logic [15:0] rem_dec;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign data_sum = running_sum + data_byte;
  assign rem_dec  = bytes_remaining - 16'd1;

  always_comb begin
    hdr_sum = TYPE_TX + FRAME_ID + RSV_HI + RSV_LO + RADIUS + tx_options;
    for (int k = 0; k < 8; k++) begin
      hdr_sum = hdr_sum + dest_address[8*k +: 8];
    end
  end

  always_comb begin
    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;
    running_sum_next     = running_sum;
    push_entry.kind  = KIND_ERR;
    push_entry.err   = 1'b1;
    push_entry.close = 1'b0;
    push_entry.dest  = dest_address;
    push_entry.opts  = tx_options;
    push_entry.lenf  = payload_length + HDR_EXTRA;
    push_entry.data  = data_byte;
    push_entry.csum  = ~hdr_sum;
    if (command == CMD_START) begin
      push_entry.kind = KIND_START;
      push_entry.err  = frame_open;
      if (payload_length == 16'd0) begin
        push_entry.close     = 1'b1;
        frame_open_next      = 1'b0;
        bytes_remaining_next = 16'd0;
        running_sum_next     = 8'd0;
      end else begin
        frame_open_next      = 1'b1;
        bytes_remaining_next = payload_length;
        running_sum_next     = hdr_sum;
      end
    end else if (frame_open) begin
      push_entry.kind = KIND_DATA;
      push_entry.err  = 1'b0;
      push_entry.csum = ~data_sum;
      if (rem_dec == 16'd0) begin
        push_entry.close     = 1'b1;
        frame_open_next      = 1'b0;
        bytes_remaining_next = 16'd0;
        running_sum_next     = 8'd0;
      end else begin
        bytes_remaining_next = rem_dec;
        running_sum_next     = data_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= 16'd0;
      running_sum     <= 8'd0;
    end else if (push) begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
      running_sum     <= running_sum_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/etfb_queue.sv =====
`default_nettype none
module etfb_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire etfb_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output etfb_pkg::entry_t      head_entry
);
  import etfb_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/etfb_back.sv =====
`default_nettype none
module etfb_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire etfb_pkg::entry_t head_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  last_of_run,
  output logic                  frame_done,
  output logic                  sequence_error
);
  import etfb_pkg::*;

  logic [4:0] idx;
  logic       esc_phase;
  logic       adv;
  logic [7:0] raw;
  logic       is_cs;
  logic       is_delim;
  logic       last_pos;
  logic       do_esc;
  logic       pos_done;
  logic [7:0] byte_next;

  assign adv = head_valid && (!out_valid || !out_stall);

  always_comb begin
    raw      = head_entry.csum;
    is_cs    = 1'b0;
    is_delim = 1'b0;
    last_pos = 1'b1;
    case (head_entry.kind)
      KIND_START: begin
        last_pos = (idx == POS_CS_START) ||
                   (idx == POS_HDR_LAST && !head_entry.close);
        is_cs    = (idx == POS_CS_START);
        case (idx)
          5'd0:    begin
            raw      = START_DELIM;
            is_delim = 1'b1;
          end
          5'd1:    raw = head_entry.lenf[15:8];
          5'd2:    raw = head_entry.lenf[7:0];
          5'd3:    raw = TYPE_TX;
          5'd4:    raw = FRAME_ID;
          5'd5:    raw = head_entry.dest[63:56];
          5'd6:    raw = head_entry.dest[55:48];
          5'd7:    raw = head_entry.dest[47:40];
          5'd8:    raw = head_entry.dest[39:32];
          5'd9:    raw = head_entry.dest[31:24];
          5'd10:   raw = head_entry.dest[23:16];
          5'd11:   raw = head_entry.dest[15:8];
          5'd12:   raw = head_entry.dest[7:0];
          5'd13:   raw = RSV_HI;
          5'd14:   raw = RSV_LO;
          5'd15:   raw = RADIUS;
          5'd16:   raw = head_entry.opts;
          default: raw = head_entry.csum;
        endcase
      end
      KIND_DATA: begin
        is_cs    = (idx == POS_CS_DATA);
        last_pos = is_cs || !head_entry.close;
        raw      = is_cs ? head_entry.csum : head_entry.data;
      end
      default: begin
        raw      = 8'd0;
        is_delim = 1'b1;
      end
    endcase
  end

  assign do_esc    = needs_esc(raw) && !is_delim && !esc_phase;
  assign pos_done  = !do_esc;
  assign byte_next = do_esc ? ESC_BYTE : (esc_phase ? (raw ^ ESC_XOR) : raw);
  assign pop       = adv && pos_done && last_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 5'd0;
      esc_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        if (pop) begin
          idx       <= 5'd0;
          esc_phase <= 1'b0;
        end else if (pos_done) begin
          idx       <= idx + 5'd1;
          esc_phase <= 1'b0;
        end else begin
          esc_phase <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte       <= byte_next;
      last_of_run    <= pos_done && last_pos;
      frame_done     <= pos_done && is_cs;
      sequence_error <= head_entry.err;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/escaped_api_tx_frame_builder_core.sv =====
`default_nettype none
// An accepted item is written to the queue; the byte sequencer then registers its
// wire bytes at the output, one wire byte per cycle while out_stall is low. A data
// item gives 1 byte (2 if escaped, 2-4 if it closes the frame), a start item 17-35.
// A 2-word queue lets the input side run ahead while the output side stalls.
// Reset (rst, synchronous): no frame open, queue empty, no output pending.
module escaped_api_tx_frame_builder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [63:0] dest_address,
  input  wire logic [7:0]  tx_options,
  input  wire logic [15:0] payload_length,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             frame_done,
  output logic             sequence_error
);
  import etfb_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  etfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .dest_address   (dest_address),
    .tx_options     (tx_options),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .push           (push),
    .push_entry     (push_entry),
    .q_full         (q_full)
  );

  etfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  etfb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .frame_done     (frame_done),
    .sequence_error (sequence_error)
  );

endmodule
`default_nettype wire
